// ===== src/e2q_pkg.sv =====
// Package for the Euler-to-quaternion block: widths, CORDIC constants, arctangent table.
// Used by every module of the block; depends on nothing.
package e2q_pkg;
    localparam int ANGLE_W     = 18;
    localparam int QUAT_W      = 16;
    localparam int Z_W         = 30;
    localparam int D_W         = 34;
    localparam int TABLE_LEN   = 24;
    localparam int TRIG_STAGES_DEF = 16;
    localparam logic signed [ANGLE_W-1:0] HALF_QUARTER  = 18'sd46080;
    localparam logic signed [ANGLE_W:0]   HALF_HALFTURN = 19'sd92160;
    localparam logic signed [D_W-1:0]     GAIN_Q30      = 34'sd652032874;

    typedef logic signed [D_W-1:0] t_data;
    typedef logic signed [Z_W-1:0] t_angle;

    typedef struct packed {
        t_data  x;
        t_data  y;
        t_angle z;
        logic   flip;
    } t_rot;

    function automatic t_angle atan_tab(input int i);
        case (i)
            0: atan_tab = 30'sd47185920;  1: atan_tab = 30'sd27855475;
            2: atan_tab = 30'sd14718068;  3: atan_tab = 30'sd7471121;
            4: atan_tab = 30'sd3750058;   5: atan_tab = 30'sd1876857;
            6: atan_tab = 30'sd938658;    7: atan_tab = 30'sd469357;
            8: atan_tab = 30'sd234682;    9: atan_tab = 30'sd117342;
            10: atan_tab = 30'sd58671;    11: atan_tab = 30'sd29335;
            12: atan_tab = 30'sd14668;    13: atan_tab = 30'sd7334;
            14: atan_tab = 30'sd3667;     15: atan_tab = 30'sd1833;
            16: atan_tab = 30'sd917;      17: atan_tab = 30'sd458;
            18: atan_tab = 30'sd229;      19: atan_tab = 30'sd115;
            20: atan_tab = 30'sd57;       21: atan_tab = 30'sd29;
            22: atan_tab = 30'sd14;       23: atan_tab = 30'sd7;
            default: atan_tab = '0;
        endcase
    endfunction

    // Rounded Q30 product of two Q30 values.
    function automatic t_data mulq30(input t_data a, input t_data b);
        logic signed [2*D_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        mulq30 = t_data'(p >>> 30);
    endfunction
endpackage

// ===== src/e2q_cell.sv =====
// One CORDIC rotation cell: a registered micro-rotation by atan(2^-STAGE).
// Depends on e2q_pkg.
module e2q_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  e2q_pkg::t_rot  i_rot,
    output e2q_pkg::t_rot  o_rot
);
    import e2q_pkg::*;

    t_rot n_rot, r_rot;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[Z_W-1]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y + (i_rot.x >>> STAGE);
            n_rot.z = i_rot.z - atan_tab(STAGE);
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STAGE);
            n_rot.y = i_rot.y - (i_rot.x >>> STAGE);
            n_rot.z = i_rot.z + atan_tab(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_rot = r_rot;
endmodule

// ===== src/e2q_sincos.sv =====
// Half-angle sine and cosine: quadrant fold, then a chain of CORDIC cells.
// Depends on e2q_pkg and e2q_cell.
module e2q_sincos #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle,
    output e2q_pkg::t_data                      o_sin,
    output e2q_pkg::t_data                      o_cos
);
    import e2q_pkg::*;

    localparam int NS = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;

    t_rot chain [NS+1];
    t_rot n_start, r_start;
    logic signed [ANGLE_W:0] h;

    always_comb begin
        h = {i_angle[ANGLE_W-1], i_angle};
        n_start.flip = 1'b0;
        if (i_angle > HALF_QUARTER) begin
            h = h - HALF_HALFTURN;
            n_start.flip = 1'b1;
        end else if (i_angle < -HALF_QUARTER) begin
            h = h + HALF_HALFTURN;
            n_start.flip = 1'b1;
        end
        n_start.x = GAIN_Q30;
        n_start.y = '0;
        n_start.z = t_angle'(h) <<< 11;
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    assign chain[0] = r_start;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        e2q_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_rot (chain[g]),
            .o_rot (chain[g+1])
        );
    end

    assign o_sin = chain[NS].flip ? -chain[NS].y : chain[NS].y;
    assign o_cos = chain[NS].flip ? -chain[NS].x : chain[NS].x;
endmodule

// ===== src/euler_to_quaternion.sv =====
// Top level: ZYX Euler angles to unit quaternion, fixed point.
// Depends on e2q_pkg and e2q_sincos.
//
// Usage. Drive i_roll_deg, i_pitch_deg and i_yaw_deg (degrees times 256) and
// pulse i_start. The word is taken at any edge with i_start high and o_busy
// low; o_busy is always low, since the datapath is fully pipelined.
// A new word can therefore enter in every cycle, one item per clock.
// The pipeline registers, in order: the quadrant fold, each CORDIC cell of
// the three sine/cosine chains (which run side by side), the negated chain
// outputs, the two rounded products of each triple, and the sum, rounding
// and saturation to Q1.15.
// The result sits on o_quat_* for exactly one cycle with o_valid high.
// The receiver cannot stall; each result is taken in the cycle it appears.
// Reset (i_rst_n low, synchronous) clears only the valid pipeline, so no
// stale result is strobed after reset; data registers are not reset.
module euler_to_quaternion #(
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_roll_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_pitch_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_yaw_deg,
    output logic                                o_valid,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_z
);
    import e2q_pkg::*;

    localparam int NS  = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;
    localparam int LAT = NS + 5;

    t_data sr, cr, sp, cp, sy, cy;

    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
        .i_clk(i_clk), .i_angle(i_roll_deg), .o_sin(sr), .o_cos(cr));
    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .i_clk(i_clk), .i_angle(i_pitch_deg), .o_sin(sp), .o_cos(cp));
    e2q_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .i_clk(i_clk), .i_angle(i_yaw_deg), .o_sin(sy), .o_cos(cy));

    // Registered sine/cosine values.
    t_data r_sr, r_cr, r_sp, r_cp, r_sy, r_cy;
    // First products: roll times pitch, yaw carried along.
    t_data r_cc, r_ss, r_sc, r_cs, r_sy2, r_cy2;
    // Second products: the eight triples.
    t_data r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ccs, r_ssc;

    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        r_sr <= sr; r_cr <= cr; r_sp <= sp; r_cp <= cp; r_sy <= sy; r_cy <= cy;
        r_cc  <= mulq30(r_cr, r_cp);
        r_ss  <= mulq30(r_sr, r_sp);
        r_sc  <= mulq30(r_sr, r_cp);
        r_cs  <= mulq30(r_cr, r_sp);
        r_sy2 <= r_sy;
        r_cy2 <= r_cy;
        r_ccc <= mulq30(r_cc, r_cy2);
        r_sss <= mulq30(r_ss, r_sy2);
        r_scc <= mulq30(r_sc, r_cy2);
        r_css <= mulq30(r_cs, r_sy2);
        r_csc <= mulq30(r_cs, r_cy2);
        r_scs <= mulq30(r_sc, r_sy2);
        r_ccs <= mulq30(r_cc, r_sy2);
        r_ssc <= mulq30(r_ss, r_cy2);
    end

    // Round a Q30 sum to Q15 and saturate.
    function automatic logic signed [QUAT_W-1:0] to_q15(input t_data a, input t_data b,
                                                        input logic sub);
        logic signed [D_W+1:0] s;
        logic signed [D_W+1:0] q;
        s = sub ? ({{2{a[D_W-1]}}, a} - {{2{b[D_W-1]}}, b})
                : ({{2{a[D_W-1]}}, a} + {{2{b[D_W-1]}}, b});
        q = (s + 36'sd16384) >>> 15;
        if (q > 36'sd32767) to_q15 = 16'sh7fff;
        else if (q < -36'sd32768) to_q15 = 16'sh8000;
        else to_q15 = q[QUAT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_quat_w <= to_q15(r_ccc, r_sss, 1'b0);
        o_quat_x <= to_q15(r_scc, r_css, 1'b1);
        o_quat_y <= to_q15(r_csc, r_scs, 1'b0);
        o_quat_z <= to_q15(r_ccs, r_ssc, 1'b1);
    end

    // Valid bits shadow the data pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start & ~o_busy};
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_vld[LAT-1];

    // Every accepted word must produce its result strobe.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(LAT) o_valid)
        else $error("result strobe missing");
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("strobe after reset");
endmodule
